FILE: design/evpm_pkg.sv
// Shared types, constants and helpers of the pilot and proximity monitor.
// Used by every design file of the block; depends on nothing else.
`timescale 1ns / 1ps

package evpm_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int SAMPLE_W   = 12;
    localparam int STATE_W    = 3;
    localparam int CABLE_W    = 6;
    localparam int AVAIL_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Proximity moving average
    localparam int PROX_WINDOW = 4;
    localparam int WIN_IDX_W   = $clog2(PROX_WINDOW);
    localparam int SUM_W       = SAMPLE_W + WIN_IDX_W;

    // The ladder compares the window sum, so that avg > T becomes sum >= (T + 1) * N.
    localparam logic [SUM_W-1:0] SUM_UNPLUG = SUM_W'((3500 + 1) * PROX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_13A    = SUM_W'((2950 + 1) * PROX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_20A    = SUM_W'((2580 + 1) * PROX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_32A    = SUM_W'((1650 + 1) * PROX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_63A    = SUM_W'((925 + 1) * PROX_WINDOW);
    localparam logic [SUM_W-1:0] SUM_FAULT  = SUM_W'((200 + 1) * PROX_WINDOW);

    // Charge states
    localparam logic [STATE_W-1:0] ST_A     = 3'd0;
    localparam logic [STATE_W-1:0] ST_B     = 3'd1;
    localparam logic [STATE_W-1:0] ST_C     = 3'd2;
    localparam logic [STATE_W-1:0] ST_E     = 3'd3;
    localparam logic [STATE_W-1:0] ST_FAULT = 3'd4;

    // Cable ratings in amps
    localparam logic [CABLE_W-1:0] CABLE_NONE = 6'd0;
    localparam logic [CABLE_W-1:0] CABLE_13A  = 6'd13;
    localparam logic [CABLE_W-1:0] CABLE_20A  = 6'd20;
    localparam logic [CABLE_W-1:0] CABLE_32A  = 6'd32;
    localparam logic [CABLE_W-1:0] CABLE_63A  = 6'd63;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0]  REG_VEHICLE_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0]  REG_PERIOD_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0]  REG_PERIOD_MAX    = 2'd2;
    localparam logic [CFG_DATA_W-1:0] PERIOD_MIN_RESET  = 16'd800;
    localparam logic [CFG_DATA_W-1:0] PERIOD_MAX_RESET  = 16'd1200;

    // Duty and current arithmetic
    localparam int HI20_W  = TIME_W + 5;
    localparam int DUTY_W  = TIME_W + 7;
    localparam int PROD_W  = TIME_W + AVAIL_W;
    localparam int DUTY_MIN_DIV = 20;
    localparam int DUTY_MAX_NUM = 97;
    localparam int DUTY_DEN     = 100;
    localparam int MA_PER_FULL  = 60000;
    localparam logic [AVAIL_W-1:0] MIN_CHARGE_MA = 16'd6000;
    localparam int DIV_CNT_W = $clog2(AVAIL_W);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_IDX_W     = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic                 is_tick;
        logic [TIME_W-1:0]    edge_time;
        logic                 level;
        logic [CABLE_W-1:0]   cable_a;
        logic [STATE_W-1:0]   prox_state;
    } job_t;

    typedef struct packed {
        logic                  vehicle_ready;
        logic [CFG_DATA_W-1:0] period_min;
        logic [CFG_DATA_W-1:0] period_max;
    } cfg_t;

    function automatic logic [AVAIL_W-1:0] cable_ma(input logic [CABLE_W-1:0] amps);
        logic [AVAIL_W-1:0] ma;
        case (amps)
            CABLE_13A: ma = 16'd13000;
            CABLE_20A: ma = 16'd20000;
            CABLE_32A: ma = 16'd32000;
            CABLE_63A: ma = 16'd63000;
            default:   ma = 16'd0;
        endcase
        return ma;
    endfunction

endpackage

FILE: design/evpm_req_if.sv
// Request channel: pilot edges and update ticks with a proximity sample.
// Depends on evpm_pkg for the field widths.
`timescale 1ns / 1ps

interface evpm_req_if import evpm_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [TIME_W-1:0]   edge_time_us;
    logic                pilot_level;
    logic [SAMPLE_W-1:0] prox_sample;

    modport source (output valid, req_type, edge_time_us, pilot_level, prox_sample,
                    input ready);
    modport sink (input valid, req_type, edge_time_us, pilot_level, prox_sample,
                  output ready);
endinterface

FILE: design/evpm_rsp_if.sv
// Response channel: charge state, cable rating and current limits per tick.
// Depends on evpm_pkg for the field widths.
`timescale 1ns / 1ps

interface evpm_rsp_if import evpm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STATE_W-1:0] charge_state;
    logic [CABLE_W-1:0] cable_rating_a;
    logic [AVAIL_W-1:0] available_ma;
    logic [AVAIL_W-1:0] max_charge_ma;

    modport source (output valid, charge_state, cable_rating_a, available_ma,
                    max_charge_ma, input ready);
    modport sink (input valid, charge_state, cable_rating_a, available_ma,
                  max_charge_ma, output ready);
endinterface

FILE: design/evpm_front.sv
// Front end: accepts request beats, keeps the proximity window and classifies ticks.
// Depends on evpm_pkg and evpm_req_if.
`timescale 1ns / 1ps

module evpm_front import evpm_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    evpm_req_if.sink  req,
    input  logic      q_full,
    output logic      push,
    output job_t      push_job
);

    logic [SAMPLE_W-1:0]  win_reg [PROX_WINDOW];
    logic [WIN_IDX_W-1:0] slot_reg;
    logic [WIN_IDX_W-1:0] slot_next;
    logic [SUM_W-1:0]     sum_reg;
    logic [SUM_W-1:0]     sum_next;
    logic                 tick_accept;
    logic [CABLE_W-1:0]   cable;
    logic [STATE_W-1:0]   prox_state;

    assign req.ready   = !q_full;
    assign push        = req.valid && !q_full;
    assign tick_accept = push && req.req_type;

    always_comb
    begin
        // The running sum drops the sample being overwritten and adds the new one.
        sum_next = sum_reg - SUM_W'(win_reg[slot_reg]) + SUM_W'(req.prox_sample);
        if (slot_reg == WIN_IDX_W'(PROX_WINDOW - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end

        cable      = CABLE_NONE;
        prox_state = ST_E;
        if (sum_next >= SUM_UNPLUG)
        begin
            prox_state = ST_A;
        end
        else if (sum_next >= SUM_13A)
        begin
            cable = CABLE_13A;
        end
        else if (sum_next >= SUM_20A)
        begin
            cable = CABLE_20A;
        end
        else if (sum_next >= SUM_32A)
        begin
            cable = CABLE_32A;
        end
        else if (sum_next >= SUM_63A)
        begin
            cable = CABLE_63A;
        end
        else if (sum_next >= SUM_FAULT)
        begin
            prox_state = ST_FAULT;
        end
    end

    always_comb
    begin
        push_job.is_tick    = req.req_type;
        push_job.edge_time  = req.edge_time_us;
        push_job.level      = req.pilot_level;
        push_job.cable_a    = cable;
        push_job.prox_state = prox_state;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= '0;
            sum_reg  <= '0;
            for (int i = 0; i < PROX_WINDOW; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (tick_accept)
        begin
            slot_reg          <= slot_next;
            sum_reg           <= sum_next;
            win_reg[slot_reg] <= req.prox_sample;
        end
    end

endmodule

FILE: design/evpm_queue.sv
// Short job queue between the front end and the back end.
// Depends on evpm_pkg for the job type and depth.
`timescale 1ns / 1ps

module evpm_queue import evpm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t               slot_reg [QUEUE_DEPTH];
    logic [Q_IDX_W-1:0] wr_ptr_reg;
    logic [Q_IDX_W-1:0] rd_ptr_reg;
    logic [Q_IDX_W:0]   count_reg;
    logic [Q_IDX_W:0]   count_next;

    assign full    = (count_reg == (Q_IDX_W + 1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Q_IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                        : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

FILE: design/evpm_back.sv
// Back end: pilot measurement, duty check, iterative current divider and result register.
// Depends on evpm_pkg and evpm_rsp_if.
`timescale 1ns / 1ps

module evpm_back import evpm_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       pop,
    evpm_rsp_if.source rsp
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CMP  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]           state_reg,  state_next;
    logic [TIME_W-1:0]    high_reg,   high_next;
    logic [TIME_W-1:0]    period_reg, period_next;
    logic [TIME_W-1:0]    rise_reg,   rise_next;
    logic                 level_reg,  level_next;
    logic                 fresh_reg,  fresh_next;
    logic                 seen_reg,   seen_next;
    logic [STATE_W-1:0]   now_reg,    now_next;
    logic [STATE_W-1:0]   base_reg,   base_next;
    logic [CABLE_W-1:0]   cable_reg,  cable_next;
    logic [AVAIL_W-1:0]   avail_reg,  avail_next;
    logic [HI20_W-1:0]    hi20_reg,   hi20_next;
    logic [DUTY_W-1:0]    hi100_reg,  hi100_next;
    logic [DUTY_W-1:0]    per97_reg,  per97_next;
    logic [PROD_W-1:0]    prod_reg,   prod_next;
    logic [TIME_W-1:0]    rem_reg,    rem_next;
    logic [AVAIL_W-1:0]   dq_reg,     dq_next;
    logic [DIV_CNT_W-1:0] cnt_reg,    cnt_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATE_W-1:0]   out_state_reg, out_state_next;
    logic [CABLE_W-1:0]   out_cable_reg, out_cable_next;
    logic [AVAIL_W-1:0]   out_avail_reg, out_avail_next;
    logic [AVAIL_W-1:0]   out_max_reg,   out_max_next;

    logic [TIME_W:0]      shifted;
    logic                 q_bit;
    logic [AVAIL_W-1:0]   limit_ma;
    logic [AVAIL_W-1:0]   max_ma;
    logic [STATE_W-1:0]   final_state;
    logic                 out_free;

    assign rsp.valid          = out_valid_reg;
    assign rsp.charge_state   = out_state_reg;
    assign rsp.cable_rating_a = out_cable_reg;
    assign rsp.available_ma   = out_avail_reg;
    assign rsp.max_charge_ma  = out_max_reg;

    assign pop      = (state_reg == S_IDLE) && !q_empty;
    assign out_free = !out_valid_reg || rsp.ready;

    // One restoring step: the remainder always stays below the period.
    assign shifted = {rem_reg, dq_reg[AVAIL_W-1]};
    assign q_bit   = (shifted >= {1'b0, period_reg});

    assign limit_ma = cable_ma(cable_reg);
    assign max_ma   = (avail_reg < limit_ma) ? avail_reg : limit_ma;

    always_comb
    begin
        if (max_ma >= MIN_CHARGE_MA)
        begin
            final_state = cfg.vehicle_ready ? ST_C : ST_B;
        end
        else if (max_ma != '0)
        begin
            final_state = ST_B;
        end
        else
        begin
            final_state = base_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        high_next      = high_reg;
        period_next    = period_reg;
        rise_next      = rise_reg;
        level_next     = level_reg;
        fresh_next     = fresh_reg;
        seen_next      = seen_reg;
        now_next       = now_reg;
        base_next      = base_reg;
        cable_next     = cable_reg;
        avail_next     = avail_reg;
        hi20_next      = hi20_reg;
        hi100_next     = hi100_reg;
        per97_next     = per97_reg;
        prod_next      = prod_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_state_next = out_state_reg;
        out_cable_next = out_cable_reg;
        out_avail_next = out_avail_reg;
        out_max_next   = out_max_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    if (!q_job.is_tick)
                    begin
                        // A repeated level leaves the measurement alone.
                        if (q_job.level && !level_reg)
                        begin
                            if (seen_reg)
                            begin
                                period_next = q_job.edge_time - rise_reg;
                            end
                            rise_next  = q_job.edge_time;
                            seen_next  = 1'b1;
                            level_next = 1'b1;
                        end
                        else if (!q_job.level && level_reg)
                        begin
                            high_next  = q_job.edge_time - rise_reg;
                            fresh_next = 1'b1;
                            level_next = 1'b0;
                        end
                    end
                    else
                    begin
                        cable_next = q_job.cable_a;
                        avail_next = '0;
                        state_next = S_FIN;
                        if (q_job.cable_a == CABLE_NONE)
                        begin
                            base_next = q_job.prox_state;
                        end
                        else if (!fresh_reg || period_reg == '0)
                        begin
                            base_next = ST_E;
                        end
                        else
                        begin
                            fresh_next = 1'b0;
                            base_next  = now_reg;
                            if (period_reg >= TIME_W'(cfg.period_min) &&
                                period_reg <= TIME_W'(cfg.period_max))
                            begin
                                state_next = S_MUL;
                            end
                        end
                    end
                end
            end

            S_MUL:
            begin
                hi20_next  = HI20_W'(high_reg) * HI20_W'(DUTY_MIN_DIV);
                hi100_next = DUTY_W'(high_reg) * DUTY_W'(DUTY_DEN);
                per97_next = DUTY_W'(period_reg) * DUTY_W'(DUTY_MAX_NUM);
                prod_next  = PROD_W'(high_reg) * PROD_W'(MA_PER_FULL);
                state_next = S_CMP;
            end

            S_CMP:
            begin
                if (hi20_reg < HI20_W'(period_reg) || hi100_reg > per97_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    // Duty of at most 97 percent keeps the quotient within 16 bits, so the
                    // upper dividend bits already sit below the period.
                    rem_next   = prod_reg[PROD_W-1:AVAIL_W];
                    dq_next    = prod_reg[AVAIL_W-1:0];
                    cnt_next   = '0;
                    state_next = S_DIV;
                end
            end

            S_DIV:
            begin
                rem_next = q_bit ? TIME_W'(shifted - {1'b0, period_reg})
                                 : shifted[TIME_W-1:0];
                dq_next  = {dq_reg[AVAIL_W-2:0], q_bit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(AVAIL_W - 1))
                begin
                    avail_next = {dq_reg[AVAIL_W-2:0], q_bit};
                    state_next = S_FIN;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    now_next       = final_state;
                    out_valid_next = 1'b1;
                    out_state_next = final_state;
                    out_cable_next = cable_reg;
                    out_avail_next = avail_reg;
                    out_max_next   = max_ma;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            high_reg      <= '0;
            period_reg    <= '0;
            rise_reg      <= '0;
            level_reg     <= 1'b0;
            fresh_reg     <= 1'b0;
            seen_reg      <= 1'b0;
            now_reg       <= ST_A;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            high_reg      <= high_next;
            period_reg    <= period_next;
            rise_reg      <= rise_next;
            level_reg     <= level_next;
            fresh_reg     <= fresh_next;
            seen_reg      <= seen_next;
            now_reg       <= now_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg      <= base_next;
        cable_reg     <= cable_next;
        avail_reg     <= avail_next;
        hi20_reg      <= hi20_next;
        hi100_reg     <= hi100_next;
        per97_reg     <= per97_next;
        prod_reg      <= prod_next;
        rem_reg       <= rem_next;
        dq_reg        <= dq_next;
        cnt_reg       <= cnt_next;
        out_state_reg <= out_state_next;
        out_cable_reg <= out_cable_next;
        out_avail_reg <= out_avail_next;
        out_max_reg   <= out_max_next;
    end

    a_max_not_above_avail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_max_reg <= out_avail_reg))
        else $error("charge limit exceeds offered current");

    a_no_cable_no_current: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_cable_reg == CABLE_NONE) |->
            (out_avail_reg == '0 && out_max_reg == '0))
        else $error("current reported without a cable");

    a_enough_current_charges: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_max_reg >= MIN_CHARGE_MA) |->
            (out_state_reg == ST_B || out_state_reg == ST_C))
        else $error("sufficient current but state is neither B nor C");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (period_reg != '0))
        else $error("divider running on a zero period");

    a_fresh_consumed: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && state_next == S_MUL) |=> !fresh_reg)
        else $error("measurement not consumed by its tick");

endmodule

FILE: design/ev_pilot_proximity_monitor.sv
// Top level of the pilot and proximity monitor: configuration registers,
// front end, job queue and back end. Depends on evpm_pkg and both channel interfaces.
// A tick's result is registered; when the duty is converted it first passes the multiply,
// compare and 16-step divider states. Pilot edges: one per cycle while the queue has room;
// the back end takes no new job until the current tick's result is registered.
// Reset clears the measurement, the proximity window and the state to A at once.
`timescale 1ns / 1ps

module ev_pilot_proximity_monitor import evpm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    evpm_req_if.sink              req,
    evpm_rsp_if.source            rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic push;
    job_t push_job;
    logic q_full;
    logic pop;
    job_t pop_job;
    logic q_empty;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_VEHICLE_READY: cfg_next.vehicle_ready = cfg_data[0];
                REG_PERIOD_MIN:    cfg_next.period_min    = cfg_data;
                REG_PERIOD_MAX:    cfg_next.period_max    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vehicle_ready <= 1'b0;
            cfg_reg.period_min    <= PERIOD_MIN_RESET;
            cfg_reg.period_max    <= PERIOD_MAX_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    evpm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    evpm_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    evpm_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_job   (pop_job),
        .pop     (pop),
        .rsp     (rsp)
    );

endmodule

FILE: verif/evpm_charge_report_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the pilot and proximity monitor: mirrors register writes, predicts
// one charge report per accepted tick and compares each response beat with it.
// Depends on evpm_pkg and on the request and response channel interfaces.

module evpm_charge_report_checker import evpm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    evpm_req_if                   req,
    evpm_rsp_if                   rsp,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_count,
    output int                    reports_pending,
    output int                    reports_checked
);

    localparam logic REQ_TICK = 1'b1;

    // An average strictly above a bound selects the band named by it.
    localparam int UNPLUG_ABOVE = 3500;
    localparam int C13_ABOVE    = 2950;
    localparam int C20_ABOVE    = 2580;
    localparam int C32_ABOVE    = 1650;
    localparam int C63_ABOVE    = 925;
    localparam int FAULT_ABOVE  = 200;
    localparam int MA_PER_AMP   = 1000;

    typedef struct packed {
        logic [STATE_W-1:0] state;
        logic [CABLE_W-1:0] cable;
        logic [AVAIL_W-1:0] offer;
        logic [AVAIL_W-1:0] limit;
    } charge_report_t;

    charge_report_t reports_due [$];

    logic                  cfg_ready;
    logic [CFG_DATA_W-1:0] cfg_min;
    logic [CFG_DATA_W-1:0] cfg_max;

    logic [TIME_W-1:0]     hi_us;
    logic [TIME_W-1:0]     per_us;
    logic [TIME_W-1:0]     rise_us;
    logic                  pilot_is_high;
    logic                  fresh_meas;
    logic                  rise_known;
    logic [SAMPLE_W-1:0]   prox_hist [PROX_WINDOW];
    logic [WIN_IDX_W-1:0]  prox_ptr;
    logic [STATE_W-1:0]    cur_state;

    function automatic void advance_pilot(input logic [TIME_W-1:0] now, input logic lvl);
        if (lvl && !pilot_is_high)
        begin
            if (rise_known)
                per_us = now - rise_us;
            rise_us       = now;
            rise_known    = 1'b1;
            pilot_is_high = 1'b1;
        end
        else if (!lvl && pilot_is_high)
        begin
            hi_us         = now - rise_us;
            fresh_meas    = 1'b1;
            pilot_is_high = 1'b0;
        end
    endfunction

    // Current offered by the last complete pilot measurement, consuming it.
    function automatic logic [AVAIL_W-1:0] pilot_offer_ma();
        logic [63:0] h;
        logic [63:0] p;
        if (!fresh_meas || per_us == '0)
        begin
            cur_state = ST_E;
            return '0;
        end
        fresh_meas = 1'b0;
        if (per_us < cfg_min || per_us > cfg_max)
            return '0;
        h = 64'(hi_us);
        p = 64'(per_us);
        if (h * DUTY_MIN_DIV < p || h * DUTY_DEN > p * DUTY_MAX_NUM)
            return '0;
        return AVAIL_W'((h * MA_PER_FULL) / p);
    endfunction

    function automatic charge_report_t predict_charge_report(input logic [SAMPLE_W-1:0] sample);
        logic [SUM_W-1:0]   total;
        logic [SUM_W-1:0]   avg;
        logic [CABLE_W-1:0] amps;
        logic [AVAIL_W-1:0] offer;
        logic [AVAIL_W-1:0] cap;
        logic [AVAIL_W-1:0] limit;
        prox_hist[prox_ptr] = sample;
        prox_ptr = prox_ptr + 1'b1;
        total = '0;
        for (int i = 0; i < PROX_WINDOW; i++)
            total = total + SUM_W'(prox_hist[i]);
        avg   = SUM_W'(total / PROX_WINDOW);
        amps  = CABLE_NONE;
        offer = '0;
        limit = '0;
        if (avg > UNPLUG_ABOVE)
            cur_state = ST_A;
        else if (avg > C13_ABOVE)
            amps = CABLE_13A;
        else if (avg > C20_ABOVE)
            amps = CABLE_20A;
        else if (avg > C32_ABOVE)
            amps = CABLE_32A;
        else if (avg > C63_ABOVE)
            amps = CABLE_63A;
        else if (avg > FAULT_ABOVE)
            cur_state = ST_FAULT;
        else
            cur_state = ST_E;
        if (amps != CABLE_NONE)
        begin
            offer = pilot_offer_ma();
            cap   = AVAIL_W'(amps * MA_PER_AMP);
            limit = (offer < cap) ? offer : cap;
            // A consumed measurement that yields nothing leaves the state alone.
            if (limit >= MIN_CHARGE_MA)
                cur_state = cfg_ready ? ST_C : ST_B;
            else if (limit != '0)
                cur_state = ST_B;
        end
        return '{state: cur_state, cable: amps, offer: offer, limit: limit};
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        charge_report_t want;
        if (!rst_n)
        begin
            cfg_ready     = 1'b0;
            cfg_min       = PERIOD_MIN_RESET;
            cfg_max       = PERIOD_MAX_RESET;
            hi_us         = '0;
            per_us        = '0;
            rise_us       = '0;
            pilot_is_high = 1'b0;
            fresh_meas    = 1'b0;
            rise_known    = 1'b0;
            foreach (prox_hist[i])
                prox_hist[i] = '0;
            prox_ptr      = '0;
            cur_state     = ST_A;
            reports_due.delete();
            mismatch_count  = 0;
            reports_checked = 0;
        end
        else
        begin
            // Responses first: a tick accepted on this edge cannot answer on it.
            if (rsp.valid && rsp.ready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("unexpected report beat: charge_state %0d, cable_rating_a %0d",
                           rsp.charge_state, rsp.cable_rating_a);
                    mismatch_count++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("charge_state", want.state, rsp.charge_state);
                    check_field("cable_rating_a", want.cable, rsp.cable_rating_a);
                    check_field("available_ma", want.offer, rsp.available_ma);
                    check_field("max_charge_ma", want.limit, rsp.max_charge_ma);
                    reports_checked++;
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_VEHICLE_READY: cfg_ready = cfg_data[0];
                    REG_PERIOD_MIN:    cfg_min   = cfg_data;
                    REG_PERIOD_MAX:    cfg_max   = cfg_data;
                    default:           ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.req_type == REQ_TICK)
                    reports_due.push_back(predict_charge_report(req.prox_sample));
                else
                    advance_pilot(req.edge_time_us, req.pilot_level);
            end
        end
        reports_pending = reports_due.size();
    end

endmodule

FILE: verif/tb_ev_pilot_proximity_monitor.sv
`timescale 1ns / 1ps
// Top of the pilot and proximity monitor testbench: clock, reset, stimulus and verdict.
// Depends on evpm_pkg, both channel interfaces, the design and the report checker.

module tb_ev_pilot_proximity_monitor;
    import evpm_pkg::*;

    localparam logic REQ_EDGE = 1'b0;
    localparam logic REQ_TICK = 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 30;
    localparam int RSP_HOLD_CYCLES = 150;
    localparam int IDLE_PCT        = 29;
    localparam int RUN_LIMIT_NS    = 1_000_000;
    localparam logic [TIME_W-1:0] WRAP_BASE = 32'hFFFF_FE00;

    // Proximity bands in order: unplugged, 13 A, 20 A, 32 A, 63 A, fault, no power.
    int band_lo [7] = '{3501, 2951, 2581, 1651, 926, 201, 0};
    int band_hi [7] = '{4095, 3500, 2950, 2580, 1650, 925, 200};

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatch_count;
    int reports_pending;
    int reports_checked;

    bit                    steady;
    int                    rsp_hold_req;
    int                    items_sent;
    int                    settings_used;
    int                    plug_band;
    logic [TIME_W-1:0]     last_rise;
    logic                  pilot_high;
    logic [CFG_DATA_W-1:0] cur_min;
    logic [CFG_DATA_W-1:0] cur_max;

    evpm_req_if req_ch ();
    evpm_rsp_if rsp_ch ();

    ev_pilot_proximity_monitor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    evpm_charge_report_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req             (req_ch),
        .rsp             (rsp_ch),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending),
        .reports_checked (reports_checked)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Response side: random back-pressure, or a counted hold-off when one is requested.
    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rsp_hold_req > 0)
            begin
                hold_left    = rsp_hold_req;
                rsp_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else
                rsp_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    task automatic send_item(input logic kind, input logic [TIME_W-1:0] stamp,
                             input logic lvl, input logic [SAMPLE_W-1:0] sample);
        int gap;
        // Each cycle before the beat is idle with the same odds.
        gap = 0;
        if (!steady)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.edge_time_us <= stamp;
        req_ch.pilot_level  <= lvl;
        req_ch.prox_sample  <= sample;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_edge(input logic [TIME_W-1:0] stamp, input logic lvl);
        if (lvl && !pilot_high)
            last_rise = stamp;
        pilot_high = lvl;
        send_item(REQ_EDGE, stamp, lvl, SAMPLE_W'($urandom_range(4095)));
    endtask

    task automatic send_tick(input logic [SAMPLE_W-1:0] sample);
        send_item(REQ_TICK, $urandom(), 1'($urandom_range(1)), sample);
    endtask

    // One pilot period: rise if low, fall after the high time, then the next rising edge.
    task automatic pilot_cycle(input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] high);
        logic [TIME_W-1:0] rise_t;
        if (!pilot_high)
            send_edge(last_rise + per, 1'b1);
        rise_t = last_rise;
        send_edge(rise_t + high, 1'b0);
        send_edge(rise_t + per, 1'b1);
    endtask

    function automatic logic [SAMPLE_W-1:0] band_sample();
        return SAMPLE_W'($urandom_range(band_hi[plug_band], band_lo[plug_band]));
    endfunction

    function automatic logic [TIME_W-1:0] choose_period();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 6)
            return '0;
        if (pick < 14)
            return (pick % 2 == 0) ? TIME_W'(cur_max) + 1 : TIME_W'(cur_min) - 1;
        if (pick < 24 || cur_min > cur_max)
            return $urandom_range(70000, 1);
        return $urandom_range(cur_max, cur_min);
    endfunction

    // High time near or inside the accepted duty window of the given period.
    function automatic logic [TIME_W-1:0] choose_high(input logic [TIME_W-1:0] per);
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     pick;
        lo   = 64'(per);
        hi   = 64'(per);
        lo   = (lo + 19) / 20;
        hi   = hi * 97 / 100;
        pick = $urandom_range(99);
        if (pick < 8)
            return TIME_W'(lo - 1);
        if (pick < 16)
            return TIME_W'(hi + 1);
        if (pick < 24 || lo > hi)
            return TIME_W'(lo);
        if (pick < 32)
            return TIME_W'(hi);
        return TIME_W'(lo + (64'($urandom()) % (hi - lo + 1)));
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (reports_pending != 0)
            @(negedge clk);
        // Pilot edges give no report but may still be in flight.
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic configure(input logic ready, input logic [CFG_DATA_W-1:0] pmin,
                             input logic [CFG_DATA_W-1:0] pmax);
        wait_drained();
        write_reg(REG_VEHICLE_READY, CFG_DATA_W'(ready));
        write_reg(REG_PERIOD_MIN, pmin);
        write_reg(REG_PERIOD_MAX, pmax);
        cur_min = pmin;
        cur_max = pmax;
        settings_used++;
    endtask

    task automatic random_burst(input int count);
        int                stop_at;
        int unsigned       pick;
        logic [TIME_W-1:0] per;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(99);
            // The plug stays in one band for a while so the average settles there.
            if (pick % 11 == 0)
                plug_band = ($urandom_range(99) < 80) ? $urandom_range(4, 1)
                                                      : $urandom_range(6, 0);
            if (pick < 65)
            begin
                per = choose_period();
                pilot_cycle(per, choose_high(per));
                repeat ($urandom_range(2, 1)) send_tick(band_sample());
            end
            else if (pick < 78)
                send_tick(band_sample());
            else if (pick < 86)
                send_tick(SAMPLE_W'($urandom_range(4095)));
            else if (pick < 94)
                send_edge(last_rise + $urandom_range(3000), 1'($urandom_range(1)));
            else
                send_edge($urandom(), pilot_high);
        end
    endtask

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.req_type     = REQ_EDGE;
        req_ch.edge_time_us = '0;
        req_ch.pilot_level  = 1'b0;
        req_ch.prox_sample  = '0;
        items_sent    = 0;
        settings_used = 1;
        plug_band     = 1;
        last_rise     = '0;
        pilot_high    = 1'b0;
        cur_min       = PERIOD_MIN_RESET;
        cur_max       = PERIOD_MAX_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // Walk the window from empty to full scale: no power, 63, 32, 13 A, unplugged.
        send_tick('0);
        repeat (4) send_tick('1);
        // First rise gives no period; the tick after the falling edge still reads unplugged.
        send_edge(WRAP_BASE, 1'b1);
        send_edge(WRAP_BASE + 500, 1'b0);
        send_tick(12'd2800);
        // The next rise lies past the timestamp wrap.
        send_edge(WRAP_BASE + 1000, 1'b1);
        send_tick('0);
        send_tick(12'd2800);
        send_edge(WRAP_BASE + 1007, 1'b1);
        pilot_cycle(1000, 50);
        send_tick(12'd2000);
        pilot_cycle(1000, 971);
        send_tick(12'd2000);
        pilot_cycle(1201, 600);
        send_tick(12'd2000);

        configure(1'b1, PERIOD_MIN_RESET, PERIOD_MAX_RESET);
        random_burst(70);

        // Hold the response side while ticks keep coming, so the request side backs up.
        @(posedge clk);
        rsp_hold_req = RSP_HOLD_CYCLES;
        repeat (12) send_tick(band_sample());
        wait_drained();

        configure(1'b1, '0, '1);
        random_burst(65);
        configure(1'b0, '1, '0);
        random_burst(45);
        configure(1'b1, 16'd1000, 16'd1000);
        write_reg(REG_SPARE, CFG_DATA_W'($urandom_range(65535)));
        random_burst(60);

        configure(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(2000, 100)),
                  CFG_DATA_W'($urandom_range(5000, 2000)));
        steady = 1'b1;
        random_burst(60);
        steady = 1'b0;

        configure(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(1500, 0)),
                  CFG_DATA_W'($urandom_range(65535, 1000)));
        random_burst(70);

        wait_drained();
        $display("Run summary: %0d request beats, %0d charge reports checked, %0d settings.",
                 items_sent, reports_checked, settings_used);
        $display("Covered the proximity ladder, duty and period limits, timestamp wrap "
                 , "and a %0d-cycle response hold-off.", RSP_HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
